// ===== design/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// shared constants, register codes and control types for the trilinear
// cell weight pipeline
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int INDEX_BITS_DEF = 16;

    localparam int POS_W    = 32;
    localparam int CFG_W    = 48;
    localparam int CNT_W    = 16;
    localparam int CELL_W   = POS_W + 1;
    localparam int BASE_W   = CELL_W + 1;
    localparam int CORNER_W = 3;
    localparam int NUM_AXES = 3;

    localparam logic [CORNER_W-1:0] CORNER_LAST = 3'd7;
    localparam logic [POS_W-1:0]    SCALE_RESET = 32'h0001_0000;

    typedef enum logic [2:0] {
        REG_ORIGIN_X,
        REG_ORIGIN_Y,
        REG_ORIGIN_Z,
        REG_SCALE_X,
        REG_SCALE_Y,
        REG_SCALE_Z,
        REG_CELL_COUNTS,
        REG_LOW_INDEX
    } cfg_reg_t;

    typedef struct packed {
        logic mul_load;
        logic loc_load;
    } tcw_adv_t;

endpackage

// ===== design/tcw_axis.sv =====
// ----------------------------------------------------------------------------
// tcw_axis
// one axis of the locate front end: offset times scale in the first stage,
// floor cell, global base index and inside test in the second
// ----------------------------------------------------------------------------
module tcw_axis #(
    parameter int FRAC_BITS = tcw_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  tcw_pkg::tcw_adv_t                   adv,
    input  logic signed [tcw_pkg::POS_W-1:0]    pos,
    input  logic signed [tcw_pkg::POS_W-1:0]    origin,
    input  logic        [tcw_pkg::POS_W-1:0]    scale,
    input  logic        [tcw_pkg::CNT_W-1:0]    cell_count,
    input  logic signed [tcw_pkg::CNT_W-1:0]    low_index,
    output logic signed [tcw_pkg::BASE_W-1:0]   base,
    output logic        [FRAC_BITS-1:0]         frac,
    output logic                                in_region
);
    import tcw_pkg::*;

    localparam int PROD_W = 2 * CELL_W;

    logic signed [CELL_W-1:0] diff;
    logic signed [CELL_W-1:0] scale_s;
    logic signed [PROD_W-1:0] prod;

    logic signed [CELL_W-1:0] cell_reg;
    logic [FRAC_BITS-1:0]     frac1_reg;

    logic signed [BASE_W-1:0] base_next;
    logic                     inside_next;
    logic signed [BASE_W-1:0] base_reg;
    logic [FRAC_BITS-1:0]     frac_reg;
    logic                     inside_reg;

    assign diff    = CELL_W'(pos) - CELL_W'(origin);
    assign scale_s = $signed({1'b0, scale});
    assign prod    = diff * scale_s;

    always_ff @(posedge clk)
    begin
        if (adv.mul_load)
        begin
            cell_reg  <= prod[2*POS_W:POS_W];
            frac1_reg <= prod[POS_W-1 -: FRAC_BITS];
        end
    end

    assign base_next   = BASE_W'(cell_reg) + BASE_W'(low_index);
    assign inside_next = !cell_reg[CELL_W-1]
                         && (cell_reg[CELL_W-2:0] < (CELL_W-1)'(cell_count));

    always_ff @(posedge clk)
    begin
        if (adv.loc_load)
        begin
            base_reg   <= base_next;
            frac_reg   <= frac1_reg;
            inside_reg <= inside_next;
        end
    end

    assign base      = base_reg;
    assign frac      = frac_reg;
    assign in_region = inside_reg;

endmodule

// ===== design/trilinear_cell_weights.sv =====
// ----------------------------------------------------------------------------
// trilinear_cell_weights
// trilinear weights and shape derivatives of the eight cell corners around
// one particle position
// ----------------------------------------------------------------------------
//  channel  | dir | fields
//  ---------+-----+--------------------------------------------------------
//  s_axis   | in  | tdata: pos_x, pos_y, pos_z
//  m_axis   | out | tdata: corner, node_x/y/z, weight, grad_x/y/z
//           |     | tuser: inside_res, tlast: last
//  cfg      | in  | cfg_wr_en, cfg_index, cfg_data
//
//  the corner sequencer in the locate stage issues one corner per cycle unless
//  stalled; a held position moves to the locate stage as its last corner issues
//  the first corner passes the multiply, locate, pair and output registers
//  stages: multiply, locate/corner sequencer, pair products, weight/grad
//  reset clears valid bits, the corner counter and the configuration registers only
//  a stall at the output backs up through empty-stage collapse, nothing lost
// ----------------------------------------------------------------------------
module trilinear_cell_weights #(
    parameter int FRAC_BITS  = tcw_pkg::FRAC_BITS_DEF,
    parameter int INDEX_BITS = tcw_pkg::INDEX_BITS_DEF,
    localparam int OUT_BITS  = tcw_pkg::CORNER_W + 3 * INDEX_BITS
                               + (FRAC_BITS + 1) + 3 * (FRAC_BITS + 2),
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [3*tcw_pkg::POS_W-1:0]       s_tdata,   // pos_x, pos_y, pos_z
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // corner, node_x, node_y, node_z, weight, grad_x, grad_y, grad_z
    output logic [OUT_W-1:0]                  m_tdata,
    output logic                              m_tuser,   // inside_res
    output logic                              m_tlast,
    input  logic                              cfg_wr_en,
    input  logic [2:0]                        cfg_index,
    input  logic [tcw_pkg::CFG_W-1:0]         cfg_data
);
    import tcw_pkg::*;

    localparam int WW  = FRAC_BITS + 1;
    localparam int GW  = FRAC_BITS + 2;
    localparam int PW  = 2 * FRAC_BITS + 2;
    localparam int NPW = BASE_W + 1;
    localparam logic [WW-1:0] ONE  = WW'(1) << FRAC_BITS;
    localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);
    localparam logic signed [NPW-1:0] IDX_HI =
        NPW'((64'sd1 <<< (INDEX_BITS - 1)) - 64'sd1);
    localparam logic signed [NPW-1:0] IDX_LO =
        NPW'(-(64'sd1 <<< (INDEX_BITS - 1)));

    function automatic logic [WW-1:0] fmul(input logic [WW-1:0] a,
                                           input logic [WW-1:0] b);
        logic [PW-1:0] p;
        p = PW'(a) * PW'(b) + HALF;
        return p[FRAC_BITS +: WW];
    endfunction

    function automatic logic [INDEX_BITS-1:0] sat_index(input logic signed [NPW-1:0] v);
        logic signed [NPW-1:0] s;
        s = v;
        if (v > IDX_HI)
            s = IDX_HI;
        else if (v < IDX_LO)
            s = IDX_LO;
        return s[INDEX_BITS-1:0];
    endfunction

    function automatic logic [GW-1:0] signed_grad(input logic positive,
                                                  input logic [WW-1:0] mag);
        logic [GW-1:0] m;
        m = GW'(mag);
        return positive ? m : GW'(-m);
    endfunction

    // configuration registers
    logic [POS_W-1:0] origin_reg [NUM_AXES];
    logic [POS_W-1:0] scale_reg  [NUM_AXES];
    logic [CFG_W-1:0] cnt_reg;
    logic [CFG_W-1:0] lo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                origin_reg[a] <= '0;
                scale_reg[a]  <= SCALE_RESET;
            end
            cnt_reg <= '0;
            lo_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ORIGIN_X:    origin_reg[0] <= cfg_data[POS_W-1:0];
                REG_ORIGIN_Y:    origin_reg[1] <= cfg_data[POS_W-1:0];
                REG_ORIGIN_Z:    origin_reg[2] <= cfg_data[POS_W-1:0];
                REG_SCALE_X:     scale_reg[0]  <= cfg_data[POS_W-1:0];
                REG_SCALE_Y:     scale_reg[1]  <= cfg_data[POS_W-1:0];
                REG_SCALE_Z:     scale_reg[2]  <= cfg_data[POS_W-1:0];
                REG_CELL_COUNTS: cnt_reg       <= cfg_data;
                REG_LOW_INDEX:   lo_reg        <= cfg_data;
                default:         ;
            endcase
        end
    end

    // pipeline control
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic [CORNER_W-1:0] k_reg;
    logic r1, r2, r3, r4;
    logic emit;
    tcw_adv_t adv;

    assign r4   = !v4_reg || m_tready;
    assign r3   = !v3_reg || r4;
    assign emit = v2_reg && r3;
    assign r2   = !v2_reg || (r3 && (k_reg == CORNER_LAST));
    assign r1   = !v1_reg || r2;
    assign s_tready = r1;

    assign adv.mul_load = r1 && s_tvalid;
    assign adv.loc_load = r2 && v1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            k_reg  <= '0;
        end
        else
        begin
            if (r1)
                v1_reg <= s_tvalid;
            if (r2)
                v2_reg <= v1_reg;
            if (r3)
                v3_reg <= v2_reg;
            if (r4)
                v4_reg <= v3_reg;
            if (emit)
                k_reg <= k_reg + 1'b1;
        end
    end

    // locate front end, one unit per axis
    logic signed [BASE_W-1:0] base      [NUM_AXES];
    logic [FRAC_BITS-1:0]     frac      [NUM_AXES];
    logic                     inside_ax [NUM_AXES];
    logic [WW-1:0]            w         [NUM_AXES];
    logic [INDEX_BITS-1:0]    node_next [NUM_AXES];

    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_axis
        logic bit_a;

        tcw_axis #(
            .FRAC_BITS (FRAC_BITS)
        ) u_axis (
            .clk        (clk),
            .adv        (adv),
            .pos        ($signed(s_tdata[a*POS_W +: POS_W])),
            .origin     ($signed(origin_reg[a])),
            .scale      (scale_reg[a]),
            .cell_count (cnt_reg[a*CNT_W +: CNT_W]),
            .low_index  ($signed(lo_reg[a*CNT_W +: CNT_W])),
            .base       (base[a]),
            .frac       (frac[a]),
            .in_region  (inside_ax[a])
        );

        assign bit_a        = k_reg[NUM_AXES-1-a];
        assign w[a]         = bit_a ? WW'(frac[a]) : (ONE - WW'(frac[a]));
        assign node_next[a] = sat_index(NPW'(base[a]) + NPW'(bit_a));
    end

    // stage 3: pair products of the corner factors
    logic [CORNER_W-1:0]   corner3_reg;
    logic [INDEX_BITS-1:0] node3_reg [NUM_AXES];
    logic [WW-1:0]         pxy3_reg, pyz3_reg, pxz3_reg, wz3_reg;
    logic                  inside3_reg;

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            corner3_reg <= k_reg;
            node3_reg   <= node_next;
            pxy3_reg    <= fmul(w[0], w[1]);
            pyz3_reg    <= fmul(w[1], w[2]);
            pxz3_reg    <= fmul(w[0], w[2]);
            wz3_reg     <= w[2];
            inside3_reg <= inside_ax[0] && inside_ax[1] && inside_ax[2];
        end
    end

    // stage 4: weight and signed derivatives, output register
    logic [CORNER_W-1:0]   corner4_reg;
    logic [INDEX_BITS-1:0] node4_reg [NUM_AXES];
    logic [WW-1:0]         weight4_reg;
    logic [GW-1:0]         grad4_reg [NUM_AXES];
    logic                  inside4_reg;
    logic                  last4_reg;

    always_ff @(posedge clk)
    begin
        if (r4 && v3_reg)
        begin
            corner4_reg  <= corner3_reg;
            node4_reg    <= node3_reg;
            weight4_reg  <= fmul(pxy3_reg, wz3_reg);
            grad4_reg[0] <= signed_grad(corner3_reg[2], pyz3_reg);
            grad4_reg[1] <= signed_grad(corner3_reg[1], pxz3_reg);
            grad4_reg[2] <= signed_grad(corner3_reg[0], pxy3_reg);
            inside4_reg  <= inside3_reg;
            last4_reg    <= (corner3_reg == CORNER_LAST);
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = OUT_W'({grad4_reg[2], grad4_reg[1], grad4_reg[0], weight4_reg,
                              node4_reg[2], node4_reg[1], node4_reg[0], corner4_reg});
    assign m_tuser  = inside4_reg;
    assign m_tlast  = last4_reg;

    // checks
    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (corner4_reg == CORNER_LAST)))
        else $error("tlast does not match corner number");

    a_seq_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (k_reg != '0) |-> v2_reg)
        else $error("corner counter running without an item");

    a_seq_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (k_reg != CORNER_LAST)) |=> v2_reg)
        else $error("item left the sequencer before its last corner");

    a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (k_reg == $past(k_reg) + 1'b1))
        else $error("corner counter skipped");

endmodule
